FILE: sv/udtc_pkg.sv
// types, constants and microcode table for the up/down elapsed time counter
// no dependencies; imported by up_down_elapsed_time_counter_core

package udtc_pkg;

  // width of the day field
  localparam int DAY_BITS = 16;

  // sequencer step counter
  localparam int STEP_BITS = 5;
  typedef logic [STEP_BITS-1:0] step_t;

  localparam step_t STEP_WAIT = 5'd0;
  localparam step_t STEP_DONE = 5'd19;

  // field selects, shared by the divider and the mixed-radix adder
  localparam logic [1:0] SEL_MS  = 2'd0;
  localparam logic [1:0] SEL_SEC = 2'd1;
  localparam logic [1:0] SEL_MIN = 2'd2;
  localparam logic [1:0] SEL_HR  = 2'd3;

  // item kinds
  typedef enum logic [1:0] {
    KIND_LOAD = 2'd0,
    KIND_UP   = 2'd1,
    KIND_DOWN = 2'd2,
    KIND_NONE = 2'd3
  } kind_e;

  // micro operations
  typedef enum logic [2:0] {
    OP_WAIT,
    OP_MUL,
    OP_REM,
    OP_FIX,
    OP_BRANCH,
    OP_MIX,
    OP_MIX_DAY,
    OP_DONE
  } op_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] amount_ms;
  } in_t;

  typedef struct packed {
    logic [DAY_BITS-1:0] days;
    logic [4:0]          hours;
    logic [5:0]          minutes;
    logic [5:0]          seconds;
    logic [9:0]          millis;
    logic                expired;
  } out_t;

  // one control word
  typedef struct packed {
    op_e        op;
    logic [1:0] sel;
    step_t      target;
  } ctrl_t;

  // radix of each sub-day field
  function automatic logic [9:0] radix(input logic [1:0] sel);
    case (sel)
      SEL_MS:  radix = 10'd1000;
      SEL_SEC: radix = 10'd60;
      SEL_MIN: radix = 10'd60;
      default: radix = 10'd24;
    endcase
  endfunction

  // floor(2^32 / radix), quotient estimate is exact or one low
  function automatic logic [31:0] recip(input logic [1:0] sel);
    case (sel)
      SEL_MS:  recip = 32'd4294967;
      SEL_SEC: recip = 32'd71582788;
      SEL_MIN: recip = 32'd71582788;
      default: recip = 32'd178956970;
    endcase
  endfunction

  function automatic ctrl_t cw(input op_e op, input logic [1:0] sel, input step_t target);
    ctrl_t c;
    c.op     = op;
    c.sel    = sel;
    c.target = target;
    return c;
  endfunction

  // microcode rom: split the amount, then for up and down items add or subtract field by field
  function automatic ctrl_t ucode(input step_t s);
    case (s)
      5'd0:    ucode = cw(OP_WAIT,    SEL_MS,  STEP_WAIT);
      5'd1:    ucode = cw(OP_MUL,     SEL_MS,  STEP_WAIT);
      5'd2:    ucode = cw(OP_REM,     SEL_MS,  STEP_WAIT);
      5'd3:    ucode = cw(OP_FIX,     SEL_MS,  STEP_WAIT);
      5'd4:    ucode = cw(OP_MUL,     SEL_SEC, STEP_WAIT);
      5'd5:    ucode = cw(OP_REM,     SEL_SEC, STEP_WAIT);
      5'd6:    ucode = cw(OP_FIX,     SEL_SEC, STEP_WAIT);
      5'd7:    ucode = cw(OP_MUL,     SEL_MIN, STEP_WAIT);
      5'd8:    ucode = cw(OP_REM,     SEL_MIN, STEP_WAIT);
      5'd9:    ucode = cw(OP_FIX,     SEL_MIN, STEP_WAIT);
      5'd10:   ucode = cw(OP_MUL,     SEL_HR,  STEP_WAIT);
      5'd11:   ucode = cw(OP_REM,     SEL_HR,  STEP_WAIT);
      5'd12:   ucode = cw(OP_FIX,     SEL_HR,  STEP_WAIT);
      5'd13:   ucode = cw(OP_BRANCH,  SEL_MS,  STEP_DONE);
      5'd14:   ucode = cw(OP_MIX,     SEL_MS,  STEP_WAIT);
      5'd15:   ucode = cw(OP_MIX,     SEL_SEC, STEP_WAIT);
      5'd16:   ucode = cw(OP_MIX,     SEL_MIN, STEP_WAIT);
      5'd17:   ucode = cw(OP_MIX,     SEL_HR,  STEP_WAIT);
      5'd18:   ucode = cw(OP_MIX_DAY, SEL_MS,  STEP_WAIT);
      5'd19:   ucode = cw(OP_DONE,    SEL_MS,  STEP_WAIT);
      default: ucode = cw(OP_WAIT,    SEL_MS,  STEP_WAIT);
    endcase
  endfunction

endpackage

FILE: sv/up_down_elapsed_time_counter_core.sv
// up/down elapsed time counter: days, hours, minutes, seconds, milliseconds
// microcoded sequencer with a shared constant divider; uses udtc_pkg
//
//   port        dir  handshake            payload
//   in_data_i   in   in_valid_i/in_stall_o   in_t  (kind, amount_ms)
//   out_data_o  out  out_valid_o/out_stall_i out_t (days..millis, expired)
//
// an up or down item runs through accept, the four constant divisions (multiply,
// remainder, correct per field), a branch on the kind, the carry or borrow chain
// through the five fields and commit; load and unused kinds branch straight to
// commit.
// reset clears the counter to zero.
// a result waits in the output register while the next item is accepted;
// a stalled output holds the sequencer at its commit step.

module up_down_elapsed_time_counter_core
  import udtc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // sequencer
  step_t step_q, step_d;
  ctrl_t ctrl;
  logic  in_xfer, out_free;

  // counter state
  logic [DAY_BITS-1:0] cnt_day_q, cnt_day_d;
  logic [4:0]          cnt_hr_q, cnt_hr_d;
  logic [5:0]          cnt_min_q, cnt_min_d;
  logic [5:0]          cnt_sec_q, cnt_sec_d;
  logic [9:0]          cnt_ms_q, cnt_ms_d;
  logic                expired_d;

  // item and divider datapath
  kind_e       kind_q;
  logic [31:0] x_q, q_q;
  logic [10:0] r_q;
  logic [63:0] prod;
  logic [31:0] back, rem;
  logic [10:0] fix_r;
  logic        fix_ge;

  // split fields
  logic [9:0] sp_ms_q;
  logic [5:0] sp_sec_q, sp_min_q;
  logic [4:0] sp_hr_q;

  // mixed-radix add or subtract
  logic [9:0]          mx_ms_q;
  logic [5:0]          mx_sec_q, mx_min_q;
  logic [4:0]          mx_hr_q;
  logic [DAY_BITS-1:0] mx_day_q;
  logic                cy_q, flag_q;
  logic [10:0]         fa, fb, fsum, fres, frad;
  logic                fcy;
  logic [DAY_BITS:0]   dsum;

  out_t out_q;
  logic out_valid_q;

  assign ctrl       = ucode(step_q);
  assign in_stall_o = (step_q != STEP_WAIT);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // next step
  always_comb begin
    step_d = step_q + 5'd1;
    case (ctrl.op)
      OP_WAIT:   step_d = in_xfer ? step_q + 5'd1 : step_q;
      OP_BRANCH: begin
        if (!(kind_q inside {KIND_UP, KIND_DOWN})) step_d = ctrl.target;
      end
      OP_DONE:   step_d = out_free ? STEP_WAIT : step_q;
      default:   step_d = step_q + 5'd1;
    endcase
  end

  // divider arithmetic
  assign prod   = 64'(x_q) * 64'(recip(ctrl.sel));
  assign back   = q_q * 32'(radix(ctrl.sel));
  assign rem    = x_q - back;
  assign fix_ge = (r_q >= 11'(radix(ctrl.sel)));
  assign fix_r  = fix_ge ? r_q - 11'(radix(ctrl.sel)) : r_q;

  // field adder operands
  always_comb begin
    case (ctrl.sel)
      SEL_MS:  begin fa = 11'(cnt_ms_q);  fb = 11'(sp_ms_q);  end
      SEL_SEC: begin fa = 11'(cnt_sec_q); fb = 11'(sp_sec_q); end
      SEL_MIN: begin fa = 11'(cnt_min_q); fb = 11'(sp_min_q); end
      default: begin fa = 11'(cnt_hr_q);  fb = 11'(sp_hr_q);  end
    endcase
    frad = 11'(radix(ctrl.sel));
    if (kind_q == KIND_DOWN) begin
      fsum = fa - fb - 11'(cy_q);
      fcy  = fsum[10];
      fres = fcy ? fsum + frad : fsum;
    end else begin
      fsum = fa + fb + 11'(cy_q);
      fcy  = (fsum >= frad);
      fres = fcy ? fsum - frad : fsum;
    end
    if (kind_q == KIND_DOWN) begin
      dsum = {1'b0, cnt_day_q} - {1'b0, x_q[DAY_BITS-1:0]} - (DAY_BITS+1)'(cy_q);
    end else begin
      dsum = {1'b0, cnt_day_q} + {1'b0, x_q[DAY_BITS-1:0]} + (DAY_BITS+1)'(cy_q);
    end
  end

  // commit values by kind
  always_comb begin
    cnt_day_d = cnt_day_q;
    cnt_hr_d  = cnt_hr_q;
    cnt_min_d = cnt_min_q;
    cnt_sec_d = cnt_sec_q;
    cnt_ms_d  = cnt_ms_q;
    expired_d = 1'b0;
    case (kind_q)
      KIND_LOAD: begin
        cnt_day_d = x_q[DAY_BITS-1:0];
        cnt_hr_d  = sp_hr_q;
        cnt_min_d = sp_min_q;
        cnt_sec_d = sp_sec_q;
        cnt_ms_d  = sp_ms_q;
      end
      KIND_UP: begin
        cnt_day_d = mx_day_q;
        cnt_hr_d  = mx_hr_q;
        cnt_min_d = mx_min_q;
        cnt_sec_d = mx_sec_q;
        cnt_ms_d  = mx_ms_q;
      end
      KIND_DOWN: begin
        expired_d = flag_q;
        if (!flag_q) begin
          cnt_day_d = mx_day_q;
          cnt_hr_d  = mx_hr_q;
          cnt_min_d = mx_min_q;
          cnt_sec_d = mx_sec_q;
          cnt_ms_d  = mx_ms_q;
        end
      end
      default: expired_d = 1'b0;
    endcase
  end

  // control and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      out_valid_q <= 1'b0;
      cnt_day_q   <= '0;
      cnt_hr_q    <= '0;
      cnt_min_q   <= '0;
      cnt_sec_q   <= '0;
      cnt_ms_q    <= '0;
    end else begin
      step_q <= step_d;
      if (ctrl.op == OP_DONE && out_free) begin
        out_valid_q <= 1'b1;
        cnt_day_q   <= cnt_day_d;
        cnt_hr_q    <= cnt_hr_d;
        cnt_min_q   <= cnt_min_d;
        cnt_sec_q   <= cnt_sec_d;
        cnt_ms_q    <= cnt_ms_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (ctrl.op)
      OP_WAIT: begin
        if (in_xfer) begin
          kind_q <= in_data_i.kind;
          x_q    <= in_data_i.amount_ms;
        end
      end
      OP_MUL: q_q <= prod[63:32];
      OP_REM: r_q <= rem[10:0];
      OP_FIX: begin
        x_q <= fix_ge ? q_q + 32'd1 : q_q;
        case (ctrl.sel)
          SEL_MS:  sp_ms_q  <= fix_r[9:0];
          SEL_SEC: sp_sec_q <= fix_r[5:0];
          SEL_MIN: sp_min_q <= fix_r[5:0];
          default: sp_hr_q  <= fix_r[4:0];
        endcase
      end
      OP_BRANCH: cy_q <= 1'b0;
      OP_MIX: begin
        cy_q <= fcy;
        case (ctrl.sel)
          SEL_MS:  mx_ms_q  <= fres[9:0];
          SEL_SEC: mx_sec_q <= fres[5:0];
          SEL_MIN: mx_min_q <= fres[5:0];
          default: mx_hr_q  <= fres[4:0];
        endcase
      end
      OP_MIX_DAY: begin
        flag_q   <= dsum[DAY_BITS];
        // saturate on overflow when counting up
        mx_day_q <= (dsum[DAY_BITS] && kind_q != KIND_DOWN) ? '1 : dsum[DAY_BITS-1:0];
      end
      OP_DONE: begin
        if (out_free) begin
          out_q.days    <= cnt_day_d;
          out_q.hours   <= cnt_hr_d;
          out_q.minutes <= cnt_min_d;
          out_q.seconds <= cnt_sec_d;
          out_q.millis  <= cnt_ms_d;
          out_q.expired <= expired_d;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // sub-day fields stay within their radix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_hr_q < 5'd24 && cnt_min_q < 6'd60 && cnt_sec_q < 6'd60 && cnt_ms_q < 10'd1000)
    else $error("counter field out of range");

  // a new result only leaves the commit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step_q) == STEP_DONE)
    else $error("result raised outside commit step");

  // the millisecond and day fields of the counter only change at commit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_ms_q) || !$stable(cnt_day_q) |-> $past(step_q) == STEP_DONE)
    else $error("counter changed outside commit step");

endmodule

FILE: sim/testbench.sv
// testbench for up_down_elapsed_time_counter_core: directed and random load, count up,
// count down and unused items, checked field by field against an in-bench counter model
// depends on udtc_pkg and the core only
`timescale 1ns / 1ps

module testbench
  import udtc_pkg::*;
();

  localparam logic [63:0] MS_PER_SEC  = 64'd1000;
  localparam logic [63:0] MS_PER_MIN  = 64'd60 * MS_PER_SEC;
  localparam logic [63:0] MS_PER_HOUR = 64'd60 * MS_PER_MIN;
  localparam logic [63:0] MS_PER_DAY  = 64'd24 * MS_PER_HOUR;
  localparam logic [63:0] DAY_LIMIT   = (64'd1 << DAY_BITS) - 64'd1;
  localparam int          TIMEOUT_NS  = 2_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // counter model state
  logic [DAY_BITS-1:0] cnt_days = '0;
  logic [4:0]          cnt_hours = '0;
  logic [5:0]          cnt_minutes = '0;
  logic [5:0]          cnt_seconds = '0;
  logic [9:0]          cnt_millis = '0;

  out_t        pending_readings[$];
  bit          no_idle = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_expired = 0;
  int unsigned n_day_limit = 0;

  up_down_elapsed_time_counter_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // time held by the counter model, in milliseconds
  function automatic logic [63:0] elapsed_ms();
    return 64'(cnt_days) * MS_PER_DAY + 64'(cnt_hours) * MS_PER_HOUR +
           64'(cnt_minutes) * MS_PER_MIN + 64'(cnt_seconds) * MS_PER_SEC +
           64'(cnt_millis);
  endfunction

  // split a millisecond total into the fields, days clamp at their maximum
  function automatic void set_from_ms(input logic [63:0] t);
    logic [63:0] d;
    cnt_millis  = 10'(t % 64'd1000);
    t           = t / 64'd1000;
    cnt_seconds = 6'(t % 64'd60);
    t           = t / 64'd60;
    cnt_minutes = 6'(t % 64'd60);
    t           = t / 64'd60;
    cnt_hours   = 5'(t % 64'd24);
    d           = t / 64'd24;
    cnt_days    = (d > DAY_LIMIT) ? DAY_BITS'(DAY_LIMIT) : DAY_BITS'(d);
  endfunction

  // apply one item to the model and return the reading it should produce
  function automatic out_t next_reading(input kind_e kind, input logic [31:0] amt);
    logic [63:0] now_ms;
    out_t        r;
    now_ms    = elapsed_ms();
    r.expired = 1'b0;
    case (kind)
      KIND_LOAD: set_from_ms(64'(amt));
      KIND_UP:   set_from_ms(now_ms + 64'(amt));
      KIND_DOWN: begin
        if (64'(amt) > now_ms) r.expired = 1'b1;
        else set_from_ms(now_ms - 64'(amt));
      end
      default: ;
    endcase
    r.days    = cnt_days;
    r.hours   = cnt_hours;
    r.minutes = cnt_minutes;
    r.seconds = cnt_seconds;
    r.millis  = cnt_millis;
    return r;
  endfunction

  // one input transfer; valid stays high when the next item follows at once
  task automatic send_item(input kind_e kind, input logic [31:0] amt);
    int unsigned gap;
    out_t        r;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{kind: kind, amount_ms: amt};
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    r = next_reading(kind, amt);
    pending_readings.push_back(r);
    n_sent++;
    if (r.expired) n_expired++;
    if (64'(r.days) == DAY_LIMIT) n_day_limit++;
  endtask

  function automatic logic [31:0] pick_amount();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 2000);
      2:       return $urandom_range(0, 3_600_000);
      default: return $urandom_range(0, 200_000_000);
    endcase
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // output side: random stall per result, check each transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_readings.size() == 0) begin
          n_errors++;
          $display("%0t ns: unexpected result, expected none, actual %p", $time,
                   out_data_o);
        end else begin
          out_t want;
          want = pending_readings.pop_front();
          n_checked++;
          compare_field("days", 32'(want.days), 32'(out_data_o.days));
          compare_field("hours", 32'(want.hours), 32'(out_data_o.hours));
          compare_field("minutes", 32'(want.minutes), 32'(out_data_o.minutes));
          compare_field("seconds", 32'(want.seconds), 32'(out_data_o.seconds));
          compare_field("millis", 32'(want.millis), 32'(out_data_o.millis));
          compare_field("expired", 32'(want.expired), 32'(out_data_o.expired));
        end
        hold_cycles = no_idle ? 0 : $urandom_range(0, 5);
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end
      out_stall_i <= (hold_cycles > 0);
    end
  end

  // unused kind reports the fields and leaves them alone
  task automatic test_unused_kind();
    send_item(KIND_NONE, 32'd0);
    send_item(KIND_LOAD, 32'd45_296_789);
    send_item(KIND_NONE, 32'hFFFF_FFFF);
  endtask

  // load splits at every radix boundary and at the widest amount
  task automatic test_load_split();
    send_item(KIND_LOAD, 32'd0);
    send_item(KIND_LOAD, 32'd999);
    send_item(KIND_LOAD, 32'd1000);
    send_item(KIND_LOAD, 32'd59_999);
    send_item(KIND_LOAD, 32'd3_599_999);
    send_item(KIND_LOAD, 32'd86_399_999);
    send_item(KIND_LOAD, 32'd86_400_000);
    send_item(KIND_LOAD, 32'hFFFF_FFFF);
  endtask

  // carries through every field
  task automatic test_count_up_carries();
    send_item(KIND_LOAD, 32'd86_399_999);
    send_item(KIND_UP, 32'd1);
    send_item(KIND_UP, 32'd0);
    send_item(KIND_UP, 32'hFFFF_FFFF);
    send_item(KIND_LOAD, 32'd3_599_999);
    send_item(KIND_UP, 32'd1);
  endtask

  // borrows, exact run-out to zero and expiry
  task automatic test_count_down_borrows();
    logic [63:0] left_ms;
    send_item(KIND_LOAD, 32'd86_400_000);
    send_item(KIND_DOWN, 32'd1);
    left_ms = elapsed_ms();
    send_item(KIND_DOWN, left_ms[31:0]);
    send_item(KIND_DOWN, 32'd1);
    send_item(KIND_DOWN, 32'd0);
    send_item(KIND_LOAD, 32'd5000);
    send_item(KIND_DOWN, 32'hFFFF_FFFF);
    send_item(KIND_DOWN, 32'd5000);
  endtask

  // pump the widest count up until days clamp, then work around the limit
  task automatic test_day_saturation();
    no_idle = 1'b1;
    send_item(KIND_LOAD, 32'd0);
    while (64'(cnt_days) != DAY_LIMIT) send_item(KIND_UP, 32'hFFFF_FFFF);
    no_idle = 1'b0;
    repeat (3) send_item(KIND_UP, 32'hFFFF_FFFF);
    send_item(KIND_UP, 32'd1);
    send_item(KIND_DOWN, 32'd1);
    send_item(KIND_DOWN, 32'hFFFF_FFFF);
    send_item(KIND_UP, 32'd86_400_000);
    send_item(KIND_NONE, 32'd0);
    send_item(KIND_LOAD, 32'd0);
  endtask

  // random mix, count downs aimed mostly at the remaining time
  task automatic test_random_mix();
    logic [63:0] now_ms;
    logic [31:0] amt;
    int unsigned pick;
    for (int i = 0; i < 750; i++) begin
      if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 3) begin
        send_item(KIND_LOAD, pick_amount());
      end else if (pick < 11) begin
        send_item(KIND_UP, pick_amount());
      end else if (pick < 19) begin
        now_ms = elapsed_ms();
        pick   = $urandom_range(0, 9);
        if (now_ms <= 64'hFFFF_FFFF && pick < 5) amt = $urandom_range(0, now_ms[31:0]);
        else if (now_ms <= 64'hFFFF_FFFF && pick == 5) amt = now_ms[31:0];
        else if (now_ms < 64'hFFFF_FFFF && pick == 6) amt = now_ms[31:0] + 32'd1;
        else amt = pick_amount();
        send_item(KIND_DOWN, amt);
      end else begin
        send_item(KIND_NONE, $urandom());
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unused_kind();
    test_load_split();
    test_count_up_carries();
    test_count_down_borrows();
    test_day_saturation();
    test_random_mix();
    in_valid_i <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("sent %0d items, checked %0d results, %0d mismatches", n_sent, n_checked,
             n_errors);
    $display("count downs expired: %0d, results at the day limit: %0d", n_expired,
             n_day_limit);
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #TIMEOUT_NS;
    $display("timeout with %0d results outstanding", pending_readings.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
